### rtl/core/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Types, constants and helpers shared by the tag presence trigger qualifier.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int TIME_W          = 32;
	localparam int CFG_W           = 16;
	localparam int LEN_W           = 3;
	localparam int UID_FIELD_BYTES = 7;
	localparam int UID_W           = 8 * UID_FIELD_BYTES;
	// longest UID the handler keeps; longer lengths saturate to this
	localparam int UID_BYTES       = 7;

	localparam logic [CFG_W-1:0] POLL_INTERVAL_RST = CFG_W'(50);
	localparam logic [CFG_W-1:0] GRACE_RST         = CFG_W'(300);
	localparam logic [CFG_W-1:0] DEBOUNCE_RST      = CFG_W'(300);
	localparam logic [CFG_W-1:0] PREEMPT_GAP_RST   = CFG_W'(350);

	typedef enum logic [1:0] {
		REG_POLL_INTERVAL = 2'd0,
		REG_GRACE         = 2'd1,
		REG_DEBOUNCE      = 2'd2,
		REG_PREEMPT_GAP   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] now_ms;
		logic              raw_present;
		logic [UID_W-1:0]  tag_uid;
		logic [LEN_W-1:0]  tag_uid_len;
		logic              led_idle;
	} poll_t;

	typedef struct packed {
		logic processed;
		logic tag_present;
		logic rising;
		logic trigger;
		logic preempt;
		logic keep_alive;
		logic hold_active;
	} res_t;

	typedef struct packed {
		logic [CFG_W-1:0] poll_interval_ms;
		logic [CFG_W-1:0] grace_ms;
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] preempt_gap_ms;
	} cfg_t;

	// byte mask over the UID field, first byte in the top bits
	function automatic logic [UID_W-1:0] uid_mask(input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] m;
		m = '0;
		for (int i = 0; i < UID_FIELD_BYTES; i++) begin
			if ({1'b0, len} > 4'(i)) begin
				m[UID_W-1-8*i -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

### rtl/core/tpq_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpq_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tpq_cfg_regs
	import tpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_interval_ms <= POLL_INTERVAL_RST;
			cfg_q.grace_ms         <= GRACE_RST;
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.preempt_gap_ms   <= PREEMPT_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_POLL_INTERVAL: cfg_q.poll_interval_ms <= cfg_data;
				REG_GRACE:         cfg_q.grace_ms         <= cfg_data;
				REG_DEBOUNCE:      cfg_q.debounce_ms      <= cfg_data;
				REG_PREEMPT_GAP:   cfg_q.preempt_gap_ms   <= cfg_data;
				default:           cfg_q                  <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/tpq_core.sv
// ----------------------------------------------------------------------------
// tpq_core
// Guard state and the per-poll decision: throttle, grace, edge, trigger,
// preempt and suppression.
// ----------------------------------------------------------------------------
module tpq_core
	import tpq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  step_en,
	input  poll_t item,
	output res_t  result
);

	logic [TIME_W-1:0] last_poll_q;
	logic              prev_present_q;
	logic              hold_q;
	logic [UID_W-1:0]  hold_uid_q;
	logic [LEN_W-1:0]  hold_cnt_q;
	logic [TIME_W-1:0] last_trig_q;
	logic [TIME_W-1:0] last_seen_q;
	logic [UID_W-1:0]  busy_uid_q;
	logic [LEN_W-1:0]  busy_cnt_q;

	logic [TIME_W-1:0] last_poll_d, last_trig_d, last_seen_d;
	logic              prev_present_d, hold_d;
	logic [UID_W-1:0]  hold_uid_d, busy_uid_d;
	logic [LEN_W-1:0]  hold_cnt_d, busy_cnt_d;

	logic [TIME_W-1:0] dt_poll, dt_seen, dt_trig;
	logic [LEN_W-1:0]  len_sat;
	logic [UID_W-1:0]  uid;
	logic              throttled, fresh, present, rising, trig, pre, keep;
	logic              same_busy, same_hold, too_fast, gap_ok;

	assign dt_poll = item.now_ms - last_poll_q;
	assign dt_seen = item.now_ms - last_seen_q;
	assign dt_trig = item.now_ms - last_trig_q;

	assign throttled = dt_poll < TIME_W'(cfg.poll_interval_ms);
	assign len_sat   = ({1'b0, item.tag_uid_len} > 4'(UID_BYTES)) ?
	                   LEN_W'(UID_BYTES) : item.tag_uid_len;
	assign uid       = item.tag_uid & uid_mask(len_sat);
	assign fresh     = item.raw_present && (len_sat != '0);
	// grace only matters on a miss, so the old seen time is the right one
	assign present   = fresh ||
	                   (hold_q && (dt_seen < TIME_W'(cfg.grace_ms)));
	assign rising    = present && !prev_present_q;

	assign same_busy = (busy_cnt_q == len_sat) && (busy_uid_q == uid);
	assign same_hold = hold_q && (hold_cnt_q == len_sat) && (hold_uid_q == uid);
	assign too_fast  = dt_trig < TIME_W'(cfg.debounce_ms);
	assign gap_ok    = dt_trig >= TIME_W'(cfg.preempt_gap_ms);

	assign pre  = rising && !item.led_idle && fresh && !same_busy && gap_ok;
	assign trig = pre || (rising && item.led_idle && fresh && !(same_hold && too_fast));
	assign keep = rising ? (item.led_idle || trig) : present;

	always_comb begin
		last_poll_d    = last_poll_q;
		prev_present_d = prev_present_q;
		hold_d         = hold_q;
		hold_uid_d     = hold_uid_q;
		hold_cnt_d     = hold_cnt_q;
		last_trig_d    = last_trig_q;
		last_seen_d    = last_seen_q;
		busy_uid_d     = busy_uid_q;
		busy_cnt_d     = busy_cnt_q;
		result         = '0;

		if (item.cmd) begin
			// reset command: guards cleared, poll time kept
			prev_present_d = 1'b0;
			hold_d         = 1'b0;
			hold_uid_d     = '0;
			hold_cnt_d     = '0;
			last_trig_d    = '0;
			last_seen_d    = '0;
			busy_uid_d     = '0;
			busy_cnt_d     = '0;
		end else if (throttled) begin
			result.tag_present = prev_present_q;
			result.hold_active = hold_q;
		end else begin
			last_poll_d    = item.now_ms;
			prev_present_d = present;
			if (fresh) begin
				last_seen_d = item.now_ms;
			end
			if (item.led_idle) begin
				busy_uid_d = '0;
				busy_cnt_d = '0;
			end
			if (trig) begin
				hold_d      = 1'b1;
				hold_uid_d  = uid;
				hold_cnt_d  = len_sat;
				busy_uid_d  = uid;
				busy_cnt_d  = len_sat;
				last_trig_d = item.now_ms;
			end else if (!present && prev_present_q) begin
				hold_d      = 1'b0;
				hold_uid_d  = '0;
				hold_cnt_d  = '0;
				last_trig_d = '0;
			end
			result.processed   = 1'b1;
			result.tag_present = present;
			result.rising      = rising;
			result.trigger     = trig;
			result.preempt     = pre;
			result.keep_alive  = keep;
			result.hold_active = hold_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_poll_q    <= '0;
			prev_present_q <= 1'b0;
			hold_q         <= 1'b0;
			hold_uid_q     <= '0;
			hold_cnt_q     <= '0;
			last_trig_q    <= '0;
			last_seen_q    <= '0;
			busy_uid_q     <= '0;
			busy_cnt_q     <= '0;
		end else if (step_en) begin
			last_poll_q    <= last_poll_d;
			prev_present_q <= prev_present_d;
			hold_q         <= hold_d;
			hold_uid_q     <= hold_uid_d;
			hold_cnt_q     <= hold_cnt_d;
			last_trig_q    <= last_trig_d;
			last_seen_q    <= last_seen_d;
			busy_uid_q     <= busy_uid_d;
			busy_cnt_q     <= busy_cnt_d;
		end
	end

endmodule

### rtl/core/tag_presence_trigger_qualifier.sv
// ----------------------------------------------------------------------------
// tag_presence_trigger_qualifier
// Qualifies tag reader polls into trigger, preempt and keep-alive decisions.
//
//   channel  dir  handshake              payload
//   poll     in   poll_valid/poll_ready  poll_t  (cmd, time, UID, idle)
//   res      out  res_valid/res_ready    res_t   (presence and decision flags)
//   cfg      in   cfg_we                 cfg_idx, cfg_data (16 bit)
//
// One word per cycle unless res_ready stalls; input and result registers.
// The decision for a word is one pass of compare/subtract logic in tpq_core.
// A stalled result holds in its register while the input register still
// takes a word; the poll side only stops when both registers are full.
// arst_n clears control, guard state and config to defaults; no clearing pass.
// ----------------------------------------------------------------------------
module tag_presence_trigger_qualifier
	import tpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             poll_valid,
	output logic             poll_ready,
	input  poll_t            poll,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t  cfg;
	poll_t item_s1;
	logic  valid_s1;
	res_t  res_q;
	logic  res_valid_q;
	res_t  step_res;
	logic  advance, take;

	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign poll_ready = !valid_s1 || advance;
	assign take       = poll_valid && poll_ready;

	tpq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tpq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (advance),
		.item    (item_s1),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= take || (valid_s1 && !advance);
			res_valid_q <= advance || (res_valid_q && !res_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= poll;
		end
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/core/tpq_checker.sv
// ----------------------------------------------------------------------------
// tpq_checker
// Port-level checks on the qualifier's result words.
// ----------------------------------------------------------------------------
module tpq_checker
	import tpq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// a trigger only comes from a processed rising edge and starts a hold
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.trigger |->
			res.processed && res.rising && res.tag_present && res.hold_active)
		else $error("trigger without processed rising edge and hold");

	// preempt is a kind of trigger and always keeps alive
	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.preempt |-> res.trigger && res.keep_alive)
		else $error("preempt without trigger or keep-alive");

	// outside a rising edge, keep-alive follows filtered presence
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.processed && !res.rising |-> res.keep_alive == res.tag_present)
		else $error("keep-alive differs from presence");

	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !res_valid)
		else $error("result valid straight out of reset");

endmodule

bind tag_presence_trigger_qualifier tpq_checker u_tpq_checker (.*);

### tb/tb_tag_presence_trigger_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tag_presence_trigger_qualifier
// Self-checking bench for the tag presence trigger qualifier. A queue-fed
// driver sends poll words, a monitor takes decision words, and an in-bench
// model of the qualifier predicts each decision for field-by-field checking.
// Runs a directed sequence and then random tag sessions under several
// register settings, with random idling on both channels except in the last run.
// ----------------------------------------------------------------------------
module tb_tag_presence_trigger_qualifier;
	import tpq_pkg::*;

	localparam logic CMD_POLL  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int   LIMIT     = 200000;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             poll_valid = 1'b0;
	logic             poll_ready;
	poll_t            poll       = '0;
	logic             res_valid;
	logic             res_ready  = 1'b0;
	res_t             res;
	logic             cfg_we     = 1'b0;
	logic [1:0]       cfg_idx    = '0;
	logic [CFG_W-1:0] cfg_data   = '0;

	tag_presence_trigger_qualifier uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll_valid),
		.poll_ready (poll_ready),
		.poll       (poll),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// qualifier model state
	cfg_t              regs;
	logic [TIME_W-1:0] last_poll_ms, seen_ms, trig_ms;
	logic              was_present, holding;
	logic [UID_W-1:0]  held_uid, owner_uid;
	logic [LEN_W-1:0]  held_len, owner_len;

	poll_t poll_backlog [$];
	res_t  due_decisions [$];
	res_t  predicted;
	int    mismatches = 0;
	int    cycle_count = 0;
	int    send_gap = 0;
	int    ready_hold = 0;
	logic  quiet = 1'b0;

	logic [TIME_W-1:0] clock_ms;
	logic [UID_W-1:0]  pool_uid [4];
	logic [LEN_W-1:0]  pool_len [4];

	function automatic logic [UID_W-1:0] valid_bytes(input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] ones;
		ones = '1;
		return ones << (8 * (UID_FIELD_BYTES - int'(len)));
	endfunction

	function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] t_now,
		input logic [TIME_W-1:0] t_then);
		return t_now - t_then;
	endfunction

	task automatic clear_guards();
		was_present = 1'b0;
		seen_ms     = '0;
		owner_uid   = '0;
		owner_len   = '0;
		holding     = 1'b0;
		held_uid    = '0;
		held_len    = '0;
		trig_ms     = '0;
	endtask

	task automatic qualify_poll(input poll_t p, output res_t r);
		logic [UID_W-1:0] uid;
		logic [LEN_W-1:0] len;
		logic             fresh, present, same_owner, same_held, recent;
		r = '0;
		if (p.cmd == CMD_CLEAR) begin
			clear_guards();
		end else if (elapsed(p.now_ms, last_poll_ms) < TIME_W'(regs.poll_interval_ms)) begin
			// throttled: state untouched, status echoed
			r.tag_present = was_present;
			r.hold_active = holding;
		end else begin
			last_poll_ms = p.now_ms;
			len = (p.tag_uid_len > UID_BYTES) ? LEN_W'(UID_BYTES) : p.tag_uid_len;
			uid = p.tag_uid & valid_bytes(len);
			fresh = p.raw_present && (len != '0);
			if (fresh) begin
				seen_ms = p.now_ms;
			end
			present = fresh ||
				(holding && elapsed(p.now_ms, seen_ms) < TIME_W'(regs.grace_ms));
			if (p.led_idle) begin
				owner_uid = '0;
				owner_len = '0;
			end
			r.rising = present && !was_present;
			if (r.rising) begin
				if (fresh && !p.led_idle) begin
					same_owner = (owner_len == len) && (owner_uid == uid);
					if (!same_owner &&
						elapsed(p.now_ms, trig_ms) >= TIME_W'(regs.preempt_gap_ms)) begin
						r.trigger = 1'b1;
						r.preempt = 1'b1;
					end
				end else if (fresh) begin
					same_held = holding && (held_len == len) && (held_uid == uid);
					recent = elapsed(p.now_ms, trig_ms) < TIME_W'(regs.debounce_ms);
					r.trigger = !(same_held && recent);
				end
				if (r.trigger) begin
					holding   = 1'b1;
					held_uid  = uid;
					held_len  = len;
					owner_uid = uid;
					owner_len = len;
					trig_ms   = p.now_ms;
				end
				// busy engine: only a preempt keeps the effect alive
				r.keep_alive = p.led_idle || r.trigger;
			end else begin
				r.keep_alive = present;
				if (!present && was_present) begin
					holding  = 1'b0;
					held_uid = '0;
					held_len = '0;
					trig_ms  = '0;
				end
			end
			was_present   = present;
			r.processed   = 1'b1;
			r.tag_present = present;
			r.hold_active = holding;
		end
	endtask

	task automatic check_bit(input string name, input logic want, input logic got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %b actual %b", $time, name, want, got);
		end
	endtask

	task automatic check_decision(input res_t got);
		res_t want;
		if (due_decisions.size() == 0) begin
			mismatches++;
			$display("%0t: result word with none expected, expected none actual %b", $time, got);
		end else begin
			want = due_decisions.pop_front();
			check_bit("processed", want.processed, got.processed);
			check_bit("tag_present", want.tag_present, got.tag_present);
			check_bit("rising", want.rising, got.rising);
			check_bit("trigger", want.trigger, got.trigger);
			check_bit("preempt", want.preempt, got.preempt);
			check_bit("keep_alive", want.keep_alive, got.keep_alive);
			check_bit("hold_active", want.hold_active, got.hold_active);
		end
	endtask

	// driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (poll_valid && poll_ready) begin
				qualify_poll(poll, predicted);
				due_decisions.push_back(predicted);
			end
			if (!poll_valid || poll_ready) begin
				if (send_gap != 0) begin
					poll_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (poll_backlog.size() != 0) begin
					poll       <= poll_backlog.pop_front();
					poll_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0) begin
						send_gap <= $urandom_range(1, 6);
					end
				end else begin
					poll_valid <= 1'b0;
				end
			end
		end
	end

	// monitor with random back-pressure bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			ready_hold <= 0;
		end else begin
			if (res_valid && res_ready) begin
				check_decision(res);
			end
			if (ready_hold != 0) begin
				res_ready  <= 1'b0;
				ready_hold <= ready_hold - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 5);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("FAIL tag_presence_trigger_qualifier");
			$finish;
		end
	end

	task automatic send_poll(input logic cmd, input logic [TIME_W-1:0] t,
		input logic raw, input logic [UID_W-1:0] uid, input logic [LEN_W-1:0] len,
		input logic idle);
		poll_t p;
		p.cmd         = cmd;
		p.now_ms      = t;
		p.raw_present = raw;
		p.tag_uid     = uid;
		p.tag_uid_len = len;
		p.led_idle    = idle;
		poll_backlog.push_back(p);
	endtask

	task automatic poll_at(input logic [TIME_W-1:0] t, input logic raw,
		input logic [UID_W-1:0] uid, input logic [LEN_W-1:0] len, input logic idle);
		clock_ms = t;
		send_poll(CMD_POLL, t, raw, uid, len, idle);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v;
		case (idx)
			REG_POLL_INTERVAL: regs.poll_interval_ms = v;
			REG_GRACE:         regs.grace_ms = v;
			REG_DEBOUNCE:      regs.debounce_ms = v;
			REG_PREEMPT_GAP:   regs.preempt_gap_ms = v;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] iv, input logic [CFG_W-1:0] gr,
		input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] gp);
		write_reg(REG_POLL_INTERVAL, iv);
		write_reg(REG_GRACE, gr);
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_PREEMPT_GAP, gp);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until every decision is back and the pipe is empty
	task automatic drain();
		do @(negedge clk);
		while (poll_backlog.size() != 0 || poll_valid || due_decisions.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] next_gap();
		int unsigned iv, gr, gp;
		iv = regs.poll_interval_ms;
		gr = regs.grace_ms;
		gp = regs.preempt_gap_ms;
		case ($urandom_range(0, 9))
			0, 1:    return $urandom_range(0, iv);
			2, 3, 4, 5, 6: return iv + $urandom_range(0, 100);
			7:       return iv + $urandom_range(0, gr + 100);
			8:       return iv + $urandom_range(0, 2 * (gr + gp) + 200);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [UID_W-1:0] dress(input logic [UID_W-1:0] uid,
		input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] junk;
		junk = UID_W'({$urandom, $urandom});
		if ($urandom_range(0, 3) == 0) begin
			return uid | (junk & ~valid_bytes(len));
		end
		return uid;
	endfunction

	task automatic refresh_pool();
		for (int k = 0; k < 4; k++) begin
			pool_len[k] = LEN_W'($urandom_range(1, 7));
			pool_uid[k] = UID_W'({$urandom, $urandom}) & valid_bytes(pool_len[k]);
		end
		// same leading bytes, different length
		pool_len[3] = (pool_len[0] == 3'd7) ? 3'd6 : pool_len[0] + 3'd1;
		pool_uid[3] = pool_uid[0] & valid_bytes(pool_len[3]);
	endtask

	task automatic add_traffic(input int target);
		int               made, roll, k, n;
		logic             raw;
		logic [LEN_W-1:0] len;
		made = 0;
		refresh_pool();
		while (made < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_poll(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)),
					UID_W'({$urandom, $urandom}), LEN_W'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)));
				made++;
			end else if (roll < 14) begin
				clock_ms = $urandom;
				send_poll(CMD_POLL, clock_ms, 1'($urandom_range(0, 1)),
					UID_W'({$urandom, $urandom}), LEN_W'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)));
				made++;
			end else begin
				// a tag session with dropouts, then an absence
				k = $urandom_range(0, 3);
				n = $urandom_range(2, 10);
				for (int i = 0; i < n; i++) begin
					clock_ms += next_gap();
					send_poll(CMD_POLL, clock_ms, $urandom_range(0, 9) < 7,
						dress(pool_uid[k], pool_len[k]), pool_len[k], $urandom_range(0, 2) != 0);
					made++;
				end
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					clock_ms += next_gap();
					raw = $urandom_range(0, 3) == 0;
					len = raw ? 3'd0 : 3'($urandom_range(0, 7));
					send_poll(CMD_POLL, clock_ms, raw, UID_W'({$urandom, $urandom}), len,
						$urandom_range(0, 2) != 0);
					made++;
				end
			end
		end
	endtask

	task automatic add_directed();
		logic [UID_W-1:0] uid_a, uid_b;
		uid_a = 56'hA1B2C3D4_000000;
		uid_b = 56'h11223344556677;
		poll_at(32'd0,    1'b0, '0, 3'd0, 1'b1);   // too soon after reset
		poll_at(32'd100,  1'b1, uid_a, 3'd4, 1'b1); // first trigger
		poll_at(32'd120,  1'b1, uid_a, 3'd4, 1'b1); // throttled while held
		poll_at(32'd200,  1'b1, uid_a, 3'd4, 1'b0);
		poll_at(32'd300,  1'b0, '0, 3'd0, 1'b0);    // bridged by grace
		poll_at(32'd700,  1'b0, '0, 3'd0, 1'b0);    // grace ran out
		poll_at(32'd800,  1'b1, uid_b, 3'd7, 1'b0); // other tag while busy
		poll_at(32'd1200, 1'b0, '0, 3'd0, 1'b0);
		poll_at(32'd1300, 1'b1, uid_b, 3'd7, 1'b0); // same busy owner
		poll_at(32'd1400, 1'b0, '0, 3'd0, 1'b1);
		poll_at(32'd1500, 1'b1, uid_a | 56'h000000_FFEEDD, 3'd4, 1'b1);
		poll_at(32'd1510, 1'b1, uid_a, 3'd4, 1'b1);
		poll_at(32'd1550, 1'b1, uid_b, 3'd0, 1'b1); // present but no length
		poll_at(32'd2000, 1'b0, uid_b, 3'd5, 1'b0);
		send_poll(CMD_CLEAR, 32'd2100, 1'b1, uid_a, 3'd4, 1'b1);
		poll_at(32'hFFFF_FFF0, 1'b1, uid_a, 3'd4, 1'b0);
		poll_at(32'h0000_0010, 1'b0, '0, 3'd0, 1'b0); // wrapped, throttled
		poll_at(32'h0000_0030, 1'b0, '0, 3'd0, 1'b0); // grace across the wrap
		poll_at(32'h0000_0200, 1'b0, '0, 3'd0, 1'b0);
		send_poll(CMD_CLEAR, 32'h0000_0210, 1'b0, '0, 3'd0, 1'b0);
		poll_at(32'h0000_0140, 1'b1, uid_b, 3'd7, 1'b0); // preempt gap not reached
		poll_at(32'h0000_0180, 1'b1, uid_b, 3'd7, 1'b1);
		poll_at(32'h0000_01C0, 1'b1, '1, 3'd7, 1'b1);
		poll_at(32'hFFFF_FFFF, 1'b0, '0, 3'd0, 1'b0);
		poll_at(32'h0000_0000, 1'b1, '1, 3'd7, 1'b0);
	endtask

	initial begin
		regs.poll_interval_ms = POLL_INTERVAL_RST;
		regs.grace_ms         = GRACE_RST;
		regs.debounce_ms      = DEBOUNCE_RST;
		regs.preempt_gap_ms   = PREEMPT_GAP_RST;
		last_poll_ms = '0;
		clear_guards();
		clock_ms = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_directed();
		drain();
		add_traffic(100);
		drain();
		set_regs(16'd0, 16'd0, 16'd0, 16'd0);
		add_traffic(100);
		drain();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_traffic(100);
		drain();
		set_regs(CFG_W'($urandom_range(10, 200)), CFG_W'($urandom_range(50, 800)),
			CFG_W'($urandom_range(50, 800)), CFG_W'($urandom_range(50, 800)));
		add_traffic(100);
		drain();
		quiet = 1'b1;
		set_regs(16'd20, 16'd150, 16'd80, 16'd200);
		add_traffic(100);
		drain();

		if (due_decisions.size() != 0) begin
			mismatches++;
			$display("%0t: decisions outstanding, expected 0 actual %0d", $time,
				due_decisions.size());
		end
		if (mismatches == 0) begin
			$display("PASS tag_presence_trigger_qualifier");
		end else begin
			$display("FAIL tag_presence_trigger_qualifier");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/tpq_pkg.sv
rtl/core/tpq_cfg_regs.sv
rtl/core/tpq_core.sv
rtl/core/tag_presence_trigger_qualifier.sv
rtl/core/tpq_checker.sv
tb/tb_tag_presence_trigger_qualifier.sv
